>>> design/gss_pkg.sv
// gss_pkg: types, constants and helpers for the glyph sequence substituter.
// No dependencies.
package gss_pkg;

  localparam int MAX_KEY_LEN   = 4;
  localparam int TABLE_ENTRIES = 16;
  localparam int CHAR_W        = 16;
  localparam int COORD_W       = 16;
  localparam int KEY_W         = CHAR_W * MAX_KEY_LEN;
  localparam int LEN_W         = 3;
  localparam int TBL_AW        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int TBL_CW        = $clog2(TABLE_ENTRIES + 1);
  localparam int WIN_AW        = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
  localparam int WIN_CW        = $clog2(MAX_KEY_LEN + 1);

  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_LOAD   = 2'd1;
  localparam logic [1:0] OP_FLUSH  = 2'd2;
  localparam logic [1:0] OP_IGNORE = 2'd3;

  localparam logic [1:0] LS_NONE   = 2'd0;
  localparam logic [1:0] LS_STORED = 2'd1;
  localparam logic [1:0] LS_FULL   = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] b;
    logic signed [COORD_W-1:0] r;
    logic signed [COORD_W-1:0] t;
    logic signed [COORD_W-1:0] l;
  } rect_t;

  typedef struct packed {
    logic [CHAR_W-1:0] repl;
    logic [LEN_W-1:0]  len;
    logic [KEY_W-1:0]  key;
  } tbl_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_UNION, ST_REPL, ST_POP, ST_LOAD
  } gss_state_t;

  // mask covering the first len characters of a key
  function automatic logic [KEY_W-1:0] key_mask(input logic [LEN_W-1:0] len);
    logic [KEY_W-1:0] m;
    m = '0;
    for (int i = 0; i < MAX_KEY_LEN; i++) begin
      if (LEN_W'(i) < len) m[CHAR_W*i +: CHAR_W] = '1;
    end
    return m;
  endfunction

  // null rectangle: right = left - 1 and bottom = top - 1 (no wrap)
  function automatic logic rect_null(input rect_t a);
    logic signed [COORD_W:0] l1, t1, r1, b1;
    l1 = {a.l[COORD_W-1], a.l};
    t1 = {a.t[COORD_W-1], a.t};
    r1 = {a.r[COORD_W-1], a.r};
    b1 = {a.b[COORD_W-1], a.b};
    return (r1 == l1 - 2'sd1) && (b1 == t1 - 2'sd1);
  endfunction

  function automatic logic signed [COORD_W-1:0] smin(input logic signed [COORD_W-1:0] a,
                                                     input logic signed [COORD_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [COORD_W-1:0] smax(input logic signed [COORD_W-1:0] a,
                                                     input logic signed [COORD_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic rect_t rect_join(input rect_t acc, input rect_t n);
    rect_t u;
    if (rect_null(acc)) begin
      u = n;
    end else if (rect_null(n)) begin
      u = acc;
    end else begin
      u.l = smin(smin(acc.l, acc.r), smin(n.l, n.r));
      u.r = smax(smax(acc.l, acc.r), smax(n.l, n.r));
      u.t = smin(smin(acc.t, acc.b), smin(n.t, n.b));
      u.b = smax(smax(acc.t, acc.b), smax(n.t, n.b));
    end
    return u;
  endfunction

endpackage

>>> design/glyph_sequence_substituter.sv
// glyph_sequence_substituter: top level, window registers, table memory, sequencer.
// Depends on gss_pkg.
//
//  channel | ports             | tdata (low bit up)                          | tuser / tlast
//  --------+-------------------+---------------------------------------------+------------------
//  in      | in_tvalid/tready  | box_char, left, top, right, bottom,         | tuser: opcode
//          |                   | key_chars, key_length, pad                  |
//  out     | out_tvalid/tready | out_char, left, top, right, bottom          | tuser: was_replaced,
//          |                   |                                             | load_status; tlast
//
// A push or a load is taken while idle; then the table is scanned with one read per entry
// from the table memory, the boxes of a matched prefix are joined one at a time into the
// rectangle union, and the words are emitted, with a closing step in ST_POP when a push
// passes no front box. A flush repeats scan and emit per drained step, up to 4 times.
// rst_n clears the counts and the control; the table and window hold no reset.
// A stalled output word holds the sequencer; in_tready is high only when idle.
module glyph_sequence_substituter
  import gss_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // box_char[15:0] left[31:16] top[47:32] right[63:48] bottom[79:64]
  // key_chars[143:80] key_length[146:144] zero pad[151:147]
  input  logic [151:0] in_tdata,
  // opcode[1:0]
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_char[15:0] left[31:16] top[47:32] right[63:48] bottom[79:64]
  output logic [79:0]  out_tdata,
  // was_replaced[0] load_status[2:1]
  output logic [2:0]   out_tuser,
  output logic         out_tlast
);

  // input fields
  logic [CHAR_W-1:0] in_char;
  rect_t             in_rect;
  logic [KEY_W-1:0]  in_key;
  logic [LEN_W-1:0]  in_len, in_len_sat;

  assign in_char    = in_tdata[15:0];
  assign in_rect.l  = in_tdata[31:16];
  assign in_rect.t  = in_tdata[47:32];
  assign in_rect.r  = in_tdata[63:48];
  assign in_rect.b  = in_tdata[79:64];
  assign in_key     = in_tdata[143:80];
  assign in_len     = in_tdata[146:144];
  assign in_len_sat = (in_len > LEN_W'(MAX_KEY_LEN)) ? LEN_W'(MAX_KEY_LEN) : in_len;

  // control state
  gss_state_t        state_r, state_nxt;
  logic [WIN_CW-1:0] win_cnt_r, win_cnt_nxt;
  logic [TBL_CW-1:0] tbl_cnt_r, tbl_cnt_nxt;
  logic [LEN_W-1:0]  longest_r, longest_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic              out_vld_r, out_vld_nxt;

  // payload state
  logic [CHAR_W-1:0] win_char_r [MAX_KEY_LEN];
  logic [CHAR_W-1:0] win_char_nxt [MAX_KEY_LEN];
  rect_t             win_rect_r [MAX_KEY_LEN];
  rect_t             win_rect_nxt [MAX_KEY_LEN];
  logic              is_load_r, is_load_nxt;
  logic              flush_r, flush_nxt;
  logic              pop_r, pop_nxt;
  logic [KEY_W-1:0]  ld_key_r, ld_key_nxt;
  logic [LEN_W-1:0]  ld_len_r, ld_len_nxt;
  logic [CHAR_W-1:0] ld_char_r, ld_char_nxt;
  logic [TBL_CW-1:0] scan_addr_r, scan_addr_nxt;
  logic [LEN_W-1:0]  best_len_r, best_len_nxt;   // zero: no match yet
  logic [CHAR_W-1:0] best_repl_r, best_repl_nxt;
  logic              hit_r, hit_nxt;
  logic [TBL_AW-1:0] hit_idx_r, hit_idx_nxt;
  logic [WIN_AW-1:0] uj_r, uj_nxt;
  rect_t             acc_r, acc_nxt;
  logic [CHAR_W-1:0] o_char_r, o_char_nxt;
  rect_t             o_rect_r, o_rect_nxt;
  logic              o_repl_r, o_repl_nxt;
  logic [1:0]        o_stat_r, o_stat_nxt;
  logic              o_last_r, o_last_nxt;

  // table memory
  tbl_entry_t        tbl_mem [TABLE_ENTRIES];
  tbl_entry_t        tbl_rd_r;
  logic              tbl_we;
  logic [TBL_AW-1:0] tbl_wa;
  tbl_entry_t        tbl_wd;

  always_ff @(posedge clk) begin
    if (tbl_we) tbl_mem[tbl_wa] <= tbl_wd;
    tbl_rd_r <= tbl_mem[scan_addr_r[TBL_AW-1:0]];
  end

  // window prefix as a key, first char in low bits
  logic [KEY_W-1:0] win_key;
  always_comb begin
    for (int i = 0; i < MAX_KEY_LEN; i++) win_key[CHAR_W*i +: CHAR_W] = win_char_r[i];
  end

  logic out_free;
  assign out_free  = !out_vld_r || out_tready;
  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    logic [WIN_CW-1:0] drop_k;
    logic              do_drop;
    logic [WIN_CW:0]   src;
    logic [WIN_CW-1:0] rem;
    logic              scan_more;
    logic              scan_done;

    state_nxt     = state_r;
    win_cnt_nxt   = win_cnt_r;
    tbl_cnt_nxt   = tbl_cnt_r;
    longest_nxt   = longest_r;
    rd_vld_nxt    = 1'b0;
    out_vld_nxt   = out_vld_r && !out_tready;
    win_char_nxt  = win_char_r;
    win_rect_nxt  = win_rect_r;
    is_load_nxt   = is_load_r;
    flush_nxt     = flush_r;
    pop_nxt       = pop_r;
    ld_key_nxt    = ld_key_r;
    ld_len_nxt    = ld_len_r;
    ld_char_nxt   = ld_char_r;
    scan_addr_nxt = scan_addr_r;
    best_len_nxt  = best_len_r;
    best_repl_nxt = best_repl_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    uj_nxt        = uj_r;
    acc_nxt       = acc_r;
    o_char_nxt    = o_char_r;
    o_rect_nxt    = o_rect_r;
    o_repl_nxt    = o_repl_r;
    o_stat_nxt    = o_stat_r;
    o_last_nxt    = o_last_r;
    tbl_we        = 1'b0;
    tbl_wa        = hit_idx_r;
    tbl_wd        = '{repl: ld_char_r, len: ld_len_r, key: ld_key_r};
    drop_k        = '0;
    do_drop       = 1'b0;
    src           = '0;
    rem           = '0;
    scan_more     = scan_addr_r < tbl_cnt_r;
    scan_done     = !scan_more && !rd_vld_r;

    unique case (state_r)
      ST_IDLE: begin
        scan_addr_nxt = '0;
        best_len_nxt  = '0;
        hit_nxt       = 1'b0;
        if (in_tvalid) begin
          unique case (in_tuser)
            OP_PUSH: begin
              is_load_nxt = 1'b0;
              flush_nxt   = 1'b0;
              if (win_cnt_r < WIN_CW'(MAX_KEY_LEN)) begin
                win_char_nxt[win_cnt_r[WIN_AW-1:0]] = in_char;
                win_rect_nxt[win_cnt_r[WIN_AW-1:0]] = in_rect;
                win_cnt_nxt = win_cnt_r + 1'b1;
              end
              pop_nxt   = LEN_W'(win_cnt_nxt) >= longest_r;
              state_nxt = ST_SCAN;
            end
            OP_LOAD: begin
              is_load_nxt = 1'b1;
              ld_len_nxt  = in_len_sat;
              ld_key_nxt  = in_key & key_mask(in_len_sat);
              ld_char_nxt = in_char;
              state_nxt   = ST_SCAN;
            end
            OP_FLUSH: begin
              if (win_cnt_r != '0) begin
                is_load_nxt = 1'b0;
                flush_nxt   = 1'b1;
                pop_nxt     = 1'b1;
                state_nxt   = ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end

      ST_SCAN: begin
        if (scan_more) begin
          rd_vld_nxt    = 1'b1;
          scan_addr_nxt = scan_addr_r + 1'b1;
        end
        if (rd_vld_r) begin
          if (is_load_r) begin
            if (tbl_rd_r.len == ld_len_r && tbl_rd_r.key == ld_key_r) begin
              hit_nxt     = 1'b1;
              hit_idx_nxt = TBL_AW'(scan_addr_r - 1'b1);
            end
          end else if (tbl_rd_r.len != '0 && tbl_rd_r.len <= LEN_W'(win_cnt_r) &&
                       (best_len_r == '0 || tbl_rd_r.len < best_len_r) &&
                       tbl_rd_r.key == (win_key & key_mask(tbl_rd_r.len))) begin
            best_len_nxt  = tbl_rd_r.len;
            best_repl_nxt = tbl_rd_r.repl;
          end
        end
        if (scan_done) begin
          if (is_load_r) begin
            state_nxt = ST_LOAD;
          end else if (best_len_r != '0) begin
            acc_nxt   = '{l: '0, t: '0, r: '1, b: '1};
            uj_nxt    = '0;
            state_nxt = ST_UNION;
          end else begin
            state_nxt = ST_POP;
          end
        end
      end

      ST_UNION: begin
        acc_nxt = rect_join(acc_r, win_rect_r[uj_r]);
        if (LEN_W'(uj_r) == best_len_r - 1'b1) state_nxt = ST_REPL;
        else uj_nxt = uj_r + 1'b1;
      end

      ST_REPL: begin
        if (out_free) begin
          rem         = win_cnt_r - WIN_CW'(best_len_r);
          out_vld_nxt = 1'b1;
          o_char_nxt  = best_repl_r;
          o_rect_nxt  = acc_r;
          o_repl_nxt  = 1'b1;
          o_stat_nxt  = LS_NONE;
          o_last_nxt  = flush_r ? (rem == '0) : !(pop_r && rem != '0);
          drop_k      = WIN_CW'(best_len_r);
          do_drop     = 1'b1;
          state_nxt   = ST_POP;
        end
      end

      ST_POP: begin
        if (pop_r && win_cnt_r != '0) begin
          if (out_free) begin
            rem         = win_cnt_r - 1'b1;
            out_vld_nxt = 1'b1;
            o_char_nxt  = win_char_r[0];
            o_rect_nxt  = win_rect_r[0];
            o_repl_nxt  = 1'b0;
            o_stat_nxt  = LS_NONE;
            o_last_nxt  = flush_r ? (rem == '0) : 1'b1;
            drop_k      = WIN_CW'(1);
            do_drop     = 1'b1;
            scan_addr_nxt = '0;
            best_len_nxt  = '0;
            state_nxt   = (flush_r && rem != '0) ? ST_SCAN : ST_IDLE;
          end
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      ST_LOAD: begin
        if (out_free) begin
          o_stat_nxt = LS_FULL;
          if (hit_r) begin
            tbl_we     = 1'b1;
            o_stat_nxt = LS_STORED;
          end else if (tbl_cnt_r < TBL_CW'(TABLE_ENTRIES)) begin
            tbl_we      = 1'b1;
            tbl_wa      = tbl_cnt_r[TBL_AW-1:0];
            tbl_cnt_nxt = tbl_cnt_r + 1'b1;
            o_stat_nxt  = LS_STORED;
          end
          if (tbl_we && ld_len_r > longest_r) longest_nxt = ld_len_r;
          out_vld_nxt = 1'b1;
          o_char_nxt  = '0;
          o_rect_nxt  = '0;
          o_repl_nxt  = 1'b0;
          o_last_nxt  = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    // shift the window forward by drop_k boxes
    if (do_drop) begin
      for (int i = 0; i < MAX_KEY_LEN; i++) begin
        src = (WIN_CW + 1)'(i) + {1'b0, drop_k};
        if (src < (WIN_CW + 1)'(MAX_KEY_LEN)) begin
          win_char_nxt[i] = win_char_r[src[WIN_AW-1:0]];
          win_rect_nxt[i] = win_rect_r[src[WIN_AW-1:0]];
        end
      end
      win_cnt_nxt = win_cnt_r - drop_k;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      win_cnt_r <= '0;
      tbl_cnt_r <= '0;
      longest_r <= '0;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      win_cnt_r <= win_cnt_nxt;
      tbl_cnt_r <= tbl_cnt_nxt;
      longest_r <= longest_nxt;
      rd_vld_r  <= rd_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_char_r  <= win_char_nxt;
    win_rect_r  <= win_rect_nxt;
    is_load_r   <= is_load_nxt;
    flush_r     <= flush_nxt;
    pop_r       <= pop_nxt;
    ld_key_r    <= ld_key_nxt;
    ld_len_r    <= ld_len_nxt;
    ld_char_r   <= ld_char_nxt;
    scan_addr_r <= scan_addr_nxt;
    best_len_r  <= best_len_nxt;
    best_repl_r <= best_repl_nxt;
    hit_r       <= hit_nxt;
    hit_idx_r   <= hit_idx_nxt;
    uj_r        <= uj_nxt;
    acc_r       <= acc_nxt;
    o_char_r    <= o_char_nxt;
    o_rect_r    <= o_rect_nxt;
    o_repl_r    <= o_repl_nxt;
    o_stat_r    <= o_stat_nxt;
    o_last_r    <= o_last_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {o_rect_r.b, o_rect_r.r, o_rect_r.t, o_rect_r.l, o_char_r};
  assign out_tuser  = {o_stat_r, o_repl_r};
  assign out_tlast  = o_last_r;

endmodule

>>> design/gss_checker.sv
// gss_checker: port-level checks for glyph_sequence_substituter, bound to the top.
// Depends on gss_pkg.
module gss_checker
  import gss_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [1:0]   in_tuser,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [79:0]  out_tdata,
  input logic [2:0]   out_tuser,
  input logic         out_tlast
);

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("stalled output word changed");

  // a load answer is a single zero word
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2:1] != LS_NONE |-> out_tlast && out_tdata == '0 && !out_tuser[0])
    else $error("load result malformed");

  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser[2:1] == LS_NONE || out_tuser[2:1] == LS_STORED
      || out_tuser[2:1] == LS_FULL)
    else $error("bad load status");

  // a push or a load always starts a scan, so the next cycle takes nothing
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == OP_PUSH || in_tuser == OP_LOAD) |=> !in_tready)
    else $error("input taken while busy");

endmodule

bind glyph_sequence_substituter gss_checker u_gss_checker (.*);

>>> tb/tb_glyph_sequence_substituter.sv
// Self-checking bench for glyph_sequence_substituter: table loads, box pushes, flushes.
// An in-bench predictor builds the expected output words; depends on gss_pkg and the RTL.
`timescale 1ns / 1ps
module tb_glyph_sequence_substituter;
  import gss_pkg::*;

  typedef struct packed {
    logic [15:0] ch;
    rect_t       rc;
    logic        repl;
    logic [1:0]  status;
    logic        last;
  } glyph_word_t;

  logic         clk, rst_n;
  logic         in_tvalid, in_tready, out_tvalid, out_tready, out_tlast;
  // box_char, left, top, right, bottom, key_chars, key_length, pad (low bit up)
  logic [151:0] in_tdata;
  // opcode
  logic [1:0]   in_tuser;
  // out_char, left, top, right, bottom (low bit up)
  logic [79:0]  out_tdata;
  // was_replaced, load_status (low bit up)
  logic [2:0]   out_tuser;

  glyph_sequence_substituter DUT (.*);

  // predictor state
  logic [15:0]       win_ch[MAX_KEY_LEN];
  rect_t             win_rc[MAX_KEY_LEN];
  int                win_n;
  logic [KEY_W-1:0]  tbl_key[TABLE_ENTRIES];
  int                tbl_len[TABLE_ENTRIES];
  logic [15:0]       tbl_rep[TABLE_ENTRIES];
  int                tbl_n, longest;

  glyph_word_t expected_words[$];
  int  errors, cycles, words_seen, replaced_seen;
  int  send_idle_pct, recv_idle_pct;
  bit  hold_off;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 900000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (hold_off) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic report(input string what, input logic [79:0] got, input logic [79:0] want);
    $display("mismatch %s: got %h want %h (word %0d)", what, got, want, words_seen);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    glyph_word_t w;
    if (rst_n && out_tvalid && out_tready) begin
      words_seen++;
      if (expected_words.size() == 0) begin
        report("unexpected word", out_tdata, '0);
      end else begin
        w = expected_words[0];
        expected_words.delete(0);
        if (out_tdata[15:0] !== w.ch) report("char", 80'(out_tdata[15:0]), 80'(w.ch));
        if (out_tdata[79:16] !== w.rc) report("rect", 80'(out_tdata[79:16]), 80'(w.rc));
        if (out_tuser[0] !== w.repl) report("was_replaced", 80'(out_tuser[0]), 80'(w.repl));
        if (out_tuser[2:1] !== w.status)
          report("load_status", 80'(out_tuser[2:1]), 80'(w.status));
        if (out_tlast !== w.last) report("last", 80'(out_tlast), 80'(w.last));
        if (w.repl) replaced_seen++;
      end
    end
  end

  function automatic bit is_null(rect_t a);
    return (int'(a.r) == int'(a.l) - 1) && (int'(a.b) == int'(a.t) - 1);
  endfunction

  function automatic rect_t merge_rect(rect_t acc, rect_t n);
    rect_t u;
    if (is_null(acc)) return n;
    if (is_null(n)) return acc;
    u.l = (acc.l < acc.r) ? acc.l : acc.r;  if (n.l < u.l) u.l = n.l;  if (n.r < u.l) u.l = n.r;
    u.r = (acc.l > acc.r) ? acc.l : acc.r;  if (n.l > u.r) u.r = n.l;  if (n.r > u.r) u.r = n.r;
    u.t = (acc.t < acc.b) ? acc.t : acc.b;  if (n.t < u.t) u.t = n.t;  if (n.b < u.t) u.t = n.b;
    u.b = (acc.t > acc.b) ? acc.t : acc.b;  if (n.t > u.b) u.b = n.t;  if (n.b > u.b) u.b = n.b;
    return u;
  endfunction

  function automatic void drop_front(int k);
    if (k > win_n) k = win_n;
    for (int i = 0; i + k < win_n; i++) begin
      win_ch[i] = win_ch[i+k];
      win_rc[i] = win_rc[i+k];
    end
    win_n -= k;
  endfunction

  function automatic void push_word(logic [15:0] ch, rect_t rc, logic repl, logic [1:0] st);
    glyph_word_t w;
    w.ch = ch; w.rc = rc; w.repl = repl; w.status = st; w.last = 1'b0;
    expected_words.insert(expected_words.size(), w);
  endfunction

  // one window step: shortest matching prefix replaced, then optional front pass
  function automatic void substitute_step(bit pop);
    logic [KEY_W-1:0] key;
    rect_t acc;
    bit hit;
    key = '0;
    hit = 0;
    for (int i = 0; i < win_n && !hit; i++) begin
      key[16*i +: 16] = win_ch[i];
      for (int e = 0; e < tbl_n && !hit; e++) begin
        if (tbl_len[e] == i + 1 && tbl_key[e] == key) begin
          acc = {16'hFFFF, 16'hFFFF, 16'h0, 16'h0};
          for (int j = 0; j <= i; j++) acc = merge_rect(acc, win_rc[j]);
          push_word(tbl_rep[e], acc, 1'b1, LS_NONE);
          drop_front(i + 1);
          hit = 1;
        end
      end
    end
    if (pop && win_n > 0) begin
      push_word(win_ch[0], win_rc[0], 1'b0, LS_NONE);
      drop_front(1);
    end
  endfunction

  function automatic void predict_glyphs(logic [1:0] op, logic [151:0] d);
    int before_n, len, st;
    logic [KEY_W-1:0] key;
    before_n = expected_words.size();
    if (op == OP_PUSH) begin
      if (win_n < MAX_KEY_LEN) begin
        win_ch[win_n] = d[15:0];
        win_rc[win_n] = d[79:16];
        win_n++;
      end
      substitute_step(win_n >= longest);
    end else if (op == OP_LOAD) begin
      len = int'(d[146:144]);
      if (len > MAX_KEY_LEN) len = MAX_KEY_LEN;
      key = d[143:80] & key_mask(LEN_W'(len));
      st = LS_FULL;
      for (int e = 0; e < tbl_n; e++)
        if (st != LS_STORED && tbl_len[e] == len && tbl_key[e] == key) begin
          tbl_rep[e] = d[15:0];
          st = LS_STORED;
        end
      if (st != LS_STORED && tbl_n < TABLE_ENTRIES) begin
        tbl_key[tbl_n] = key; tbl_len[tbl_n] = len; tbl_rep[tbl_n] = d[15:0];
        tbl_n++;
        st = LS_STORED;
      end
      if (st == LS_STORED && len > longest) longest = len;
      push_word('0, '0, 1'b0, st[1:0]);
    end else if (op == OP_FLUSH) begin
      while (win_n > 0) substitute_step(1'b1);
    end
    if (expected_words.size() > before_n)
      expected_words[expected_words.size() - 1].last = 1'b1;
  endfunction

  // offer one word, wait for acceptance, then predict
  task automatic send_item(input logic [1:0] op, input logic [151:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_glyphs(op, d);
  endtask

  function automatic logic [151:0] box_word(logic [15:0] ch, rect_t rc);
    return {72'h0, rc, ch};
  endfunction

  function automatic logic [151:0] load_word(logic [15:0] rep, logic [63:0] key, logic [2:0] len);
    return {5'h0, len, key, 64'h0, rep};
  endfunction

  function automatic rect_t rand_rect();
    rect_t r;
    r = {$urandom, $urandom};
    if ($urandom_range(7) == 0) begin
      r.r = r.l - 16'sd1; r.b = r.t - 16'sd1;
    end
    return r;
  endfunction

  task automatic drain_wait();
    in_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // small alphabet so random text hits the keys
  function automatic logic [15:0] rand_glyph();
    return ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(8'h41, 8'h46));
  endfunction

  task automatic test_directed();
    rect_t nul;
    nul = {16'hFFFF, 16'hFFFF, 16'h0, 16'h0};
    // no keys yet: every push passes straight through
    send_item(OP_PUSH, box_word(16'hFFFF, {16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000}));
    send_item(OP_FLUSH, '0);   // empty window: no words
    send_item(OP_IGNORE, '1);  // reserved opcode ignored
    send_item(OP_LOAD, load_word(16'h0058, 64'hFFFF_FFFF_FFFF_0041, 3'd1)); // extra chars ignored
    send_item(OP_LOAD, load_word(16'h0059, {16'h0, 16'h0043, 16'h0042, 16'h0041}, 3'd3));
    send_item(OP_LOAD, load_word(16'h005A, 64'hFFFF_FFFF_FFFF_FFFF, 3'd7)); // saturates to 4
    send_item(OP_LOAD, load_word(16'h1234, 64'h0, 3'd0));                    // never matches
    send_item(OP_LOAD, load_word(16'h0057, 64'hFFFF_FFFF_FFFF_0041, 3'd1)); // replace entry
    send_item(OP_PUSH, box_word(16'h0041, nul));
    send_item(OP_PUSH, box_word(16'h0041, {16'h0, 16'h0, 16'h7FFF, 16'h8000}));
    send_item(OP_PUSH, box_word(16'h0041, {16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF}));
    for (int i = 0; i < 4; i++) send_item(OP_PUSH, box_word(16'hFFFF, rand_rect()));
    send_item(OP_PUSH, box_word(16'h0042, rand_rect()));
    send_item(OP_FLUSH, '0);
    send_item(OP_PUSH, box_word(16'h0000, rand_rect()));
    send_item(OP_FLUSH, '0);
    drain_wait();
  endtask

  task automatic test_random(input int n);
    int k, len;
    logic [63:0] key;
    logic [151:0] d;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 10) begin
        len = $urandom_range(7);
        key = {rand_glyph(), rand_glyph(), rand_glyph(), rand_glyph()};
        if ($urandom_range(3) == 0) key = {$urandom, $urandom};
        send_item(OP_LOAD, load_word(16'($urandom), key, 3'(len)));
      end else if (k < 16) begin
        d = {$urandom, $urandom, $urandom, $urandom, 24'($urandom)};
        send_item(OP_FLUSH, d);
      end else if (k < 18) begin
        d = {$urandom, $urandom, $urandom, $urandom, 24'($urandom)};
        send_item(OP_IGNORE, d);
      end else begin
        // key fields carry noise, which a push ignores
        d = {$urandom, $urandom, 8'($urandom), rand_rect(), rand_glyph()};
        send_item(OP_PUSH, d);
      end
    end
    send_item(OP_FLUSH, '0);
    drain_wait();
  endtask

  // receiver stops for a long stretch while the sender keeps offering
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      test_random(20);
    join
  endtask

  initial begin
    clk = 1'b0;
    errors = 0; cycles = 0; words_seen = 0; replaced_seen = 0;
    win_n = 0; tbl_n = 0; longest = 0;
    send_idle_pct = 33; recv_idle_pct = 86; hold_off = 0;
    rst_n = 0; in_tvalid = 0; in_tdata = '0; in_tuser = '0; out_tready = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(100);
    send_idle_pct = 86; recv_idle_pct = 33;
    test_random(100);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_backpressure();
    test_random(100);
    $display("covered loads, pushes, flushes over three stall mixes and a long output stall");
    $display("%0d words checked, %0d of them replacements", words_seen, replaced_seen);
    if (errors == 0 && expected_words.size() == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
